/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands shared by the timer bank RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge, off while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never be true at a rising edge
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

/* sv/ptb_pkg.sv */
// ----------------------------------------------------------------------------
// ptb_pkg
// Types, codes and sizes shared by the periodic timer bank and its cells.
// ----------------------------------------------------------------------------
package ptb_pkg;

	localparam int NUM_TIMERS = 16;
	localparam int SLOT_W     = 4;
	localparam int SEQ_W      = 16;
	localparam int ID_W       = 20;
	localparam int PER_W      = 16;
	localparam int HND_W      = 8;
	localparam int TAG_W      = 32;

	typedef enum logic [1:0] {
		FUNC_TICK  = 2'd0,
		FUNC_ADD   = 2'd1,
		FUNC_STOP  = 2'd2,
		FUNC_CLEAR = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		KIND_ADD       = 3'd0,
		KIND_STOP      = 3'd1,
		KIND_CLEAR     = 3'd2,
		KIND_FIRE      = 3'd3,
		KIND_IDLE_TICK = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_FULL       = 3'd1,
		ST_BAD_PERIOD = 3'd2,
		ST_RANGE      = 3'd3,
		ST_STALE      = 3'd4
	} status_t;

	// command broadcast to every cell for the duration of a walk
	typedef struct packed {
		func_t              func;
		logic [PER_W-1:0]   period;
		logic [HND_W-1:0]   handler;
		logic [TAG_W-1:0]   tag;
		logic [SLOT_W-1:0]  id_slot;
		logic [SEQ_W-1:0]   id_seq;
		logic [SEQ_W-1:0]   new_seq;
	} cmd_t;

	// what the token-holding cell reports; all zero from the other cells
	typedef struct packed {
		logic               fire;
		logic               claim;
		logic               hit;
		logic [SLOT_W-1:0]  slot;
		logic [SEQ_W-1:0]   seq;
		logic [HND_W-1:0]   handler;
		logic [TAG_W-1:0]   tag;
	} evt_t;

endpackage

/* sv/ptb_cell.sv */
// ----------------------------------------------------------------------------
// ptb_cell
// One timer slot. Acts on the broadcast command when the walk token arrives,
// then hands the token and the add-claimed flag to the next cell.
// ----------------------------------------------------------------------------
module ptb_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [ptb_pkg::SLOT_W-1:0]  idx,
	input  ptb_pkg::cmd_t               cmd,
	input  logic                        tok_in,
	input  logic                        clm_in,
	output logic                        tok_out,
	output logic                        clm_out,
	output ptb_pkg::evt_t               evt
);
	import ptb_pkg::*;

	logic               live_q;
	logic [PER_W-1:0]   period_q;
	logic [PER_W-1:0]   count_q;
	logic [SEQ_W-1:0]   seq_q;
	logic [HND_W-1:0]   handler_q;
	logic [TAG_W-1:0]   tag_q;
	logic               tok_q;
	logic               clm_q;

	logic [PER_W-1:0]   count_inc;
	logic               do_count;
	logic               do_fire;
	logic               do_claim;
	logic               do_hit;

	always_comb begin
		count_inc = PER_W'(count_q + 1'b1);
		do_count  = tok_in && (cmd.func == FUNC_TICK) && live_q;
		do_fire   = do_count && (count_inc >= period_q);
		do_claim  = tok_in && (cmd.func == FUNC_ADD) && !clm_in && !live_q
			&& (cmd.period != '0);
		do_hit    = tok_in && ((cmd.func == FUNC_STOP) || (cmd.func == FUNC_CLEAR))
			&& live_q && (idx == cmd.id_slot) && (seq_q == cmd.id_seq);
	end

	always_comb begin
		evt = '0;
		if (tok_in) begin
			evt.fire    = do_fire;
			evt.claim   = do_claim;
			evt.hit     = do_hit;
			evt.slot    = idx;
			evt.seq     = seq_q;
			evt.handler = handler_q;
			evt.tag     = tag_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= 1'b0;
			tok_q  <= 1'b0;
			clm_q  <= 1'b0;
		end else begin
			tok_q <= tok_in;
			clm_q <= clm_in | do_claim;
			if (do_claim) begin
				live_q <= 1'b1;
			end else if (do_hit && (cmd.func == FUNC_STOP)) begin
				live_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_claim) begin
			period_q  <= cmd.period;
			seq_q     <= cmd.new_seq;
			handler_q <= cmd.handler;
			tag_q     <= cmd.tag;
		end
		if (do_claim) begin
			count_q <= '0;
		end else if (do_count) begin
			count_q <= do_fire ? '0 : count_inc;
		end else if (do_hit && (cmd.func == FUNC_CLEAR)) begin
			count_q <= '0;
		end
	end

	assign tok_out = tok_q;
	assign clm_out = clm_q;

endmodule

/* sv/periodic_timer_bank.sv */
// ----------------------------------------------------------------------------
// periodic_timer_bank
// A command walks all NUM_TIMERS cells, one cell per cycle; its final (or only)
//   result beat is registered from the token that leaves the last cell.
// A new command is taken only after the previous walk has ended, as the walk token
//   passes down the cell chain; busy stays high meanwhile.
// Fires of a tick come out while the walk is still running, one behind.
// Results are one-cycle strobes on valid; the receiver cannot stall.
// Reset (arst_n low, async): all slots free, sequence zero, no walk running.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module periodic_timer_bank (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  func,
	input  logic [ptb_pkg::PER_W-1:0]   period,
	input  logic [ptb_pkg::HND_W-1:0]   handler_index,
	input  logic [ptb_pkg::TAG_W-1:0]   callback_tag,
	input  logic [ptb_pkg::ID_W-1:0]    timer_id,
	output logic                        valid,
	output logic [2:0]                  kind,
	output logic [2:0]                  status,
	output logic [ptb_pkg::ID_W-1:0]    result_id,
	output logic [ptb_pkg::HND_W-1:0]   fired_handler,
	output logic [ptb_pkg::TAG_W-1:0]   fired_tag,
	output logic                        last
);
	import ptb_pkg::*;

	// --- control --------------------------------------------------------
	logic               busy_q;     // a walk is in flight
	logic               launch_q;   // token into cell 0
	cmd_t               cmd_q;      // command being walked
	logic [SEQ_W-1:0]   next_seq_q;
	logic               hit_q;      // stop/clear found its live slot
	logic [SLOT_W-1:0]  add_slot_q; // slot claimed by an add

	// One fire is held back so that the last one of a tick can carry last=1.
	logic               pend_q;
	logic [SLOT_W-1:0]  pend_slot_q;
	logic [SEQ_W-1:0]   pend_seq_q;
	logic [HND_W-1:0]   pend_handler_q;
	logic [TAG_W-1:0]   pend_tag_q;

	// --- output beat register -------------------------------------------
	logic               out_valid_q;
	kind_t              out_kind_q;
	status_t            out_status_q;
	logic [ID_W-1:0]    out_id_q;
	logic [HND_W-1:0]   out_handler_q;
	logic [TAG_W-1:0]   out_tag_q;
	logic               out_last_q;

	// --- cell chain -------------------------------------------------------
	logic [NUM_TIMERS:0]    tok_w;  // tok_w[i] is the token into cell i
	logic [NUM_TIMERS:0]    clm_w;  // an earlier cell has taken the add
	evt_t                   evt_w [NUM_TIMERS];
	evt_t                   evt_any;

	logic   accept;
	logic   walk_end;
	logic   slot_range_bad;

	assign accept   = start && !busy_q;
	assign walk_end = tok_w[NUM_TIMERS];
	assign tok_w[0] = launch_q;
	assign clm_w[0] = 1'b0;

	genvar gi;
	generate
		for (gi = 0; gi < NUM_TIMERS; gi++) begin : g_cell
			ptb_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.idx     (SLOT_W'(gi)),
				.cmd     (cmd_q),
				.tok_in  (tok_w[gi]),
				.clm_in  (clm_w[gi]),
				.tok_out (tok_w[gi+1]),
				.clm_out (clm_w[gi+1]),
				.evt     (evt_w[gi])
			);
		end
	endgenerate

	// Only the token holder drives a nonzero event, so an OR picks it out.
	always_comb begin
		evt_any = '0;
		for (int i = 0; i < NUM_TIMERS; i++) begin
			evt_any = evt_t'(evt_any | evt_w[i]);
		end
	end

	assign slot_range_bad = ({1'b0, cmd_q.id_slot} >= (SLOT_W+1)'(NUM_TIMERS));

	// --- control registers ----------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			launch_q    <= 1'b0;
			next_seq_q  <= '0;
			hit_q       <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			launch_q    <= accept;
			out_valid_q <= 1'b0;
			if (accept) begin
				busy_q <= 1'b1;
				hit_q  <= 1'b0;
				pend_q <= 1'b0;
			end else begin
				if (evt_any.hit) begin
					hit_q <= 1'b1;
				end
				if (evt_any.fire) begin
					pend_q <= 1'b1;
					if (pend_q) begin
						out_valid_q <= 1'b1;
					end
				end
				if (walk_end) begin
					busy_q      <= 1'b0;
					pend_q      <= 1'b0;
					out_valid_q <= 1'b1;
					if ((cmd_q.func == FUNC_ADD) && clm_w[NUM_TIMERS]) begin
						next_seq_q <= SEQ_W'(next_seq_q + 1'b1);
					end
				end
			end
		end
	end

	// --- payload registers ------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q.func    <= func_t'(func);
			cmd_q.period  <= period;
			cmd_q.handler <= handler_index;
			cmd_q.tag     <= callback_tag;
			cmd_q.id_slot <= timer_id[ID_W-1:SEQ_W];
			cmd_q.id_seq  <= timer_id[SEQ_W-1:0];
			cmd_q.new_seq <= next_seq_q;
		end
		if (evt_any.claim) begin
			add_slot_q <= evt_any.slot;
		end
		if (evt_any.fire) begin
			pend_slot_q    <= evt_any.slot;
			pend_seq_q     <= evt_any.seq;
			pend_handler_q <= evt_any.handler;
			pend_tag_q     <= evt_any.tag;
		end

		if (evt_any.fire && pend_q) begin
			// a newer fire pushes the held one out; it is not the last
			out_kind_q    <= KIND_FIRE;
			out_status_q  <= ST_OK;
			out_id_q      <= {pend_slot_q, pend_seq_q};
			out_handler_q <= pend_handler_q;
			out_tag_q     <= pend_tag_q;
			out_last_q    <= 1'b0;
		end else if (walk_end) begin
			out_id_q      <= '0;
			out_handler_q <= '0;
			out_tag_q     <= '0;
			out_last_q    <= 1'b1;
			out_status_q  <= ST_OK;
			unique case (cmd_q.func) inside
				FUNC_TICK: begin
					if (pend_q) begin
						out_kind_q    <= KIND_FIRE;
						out_id_q      <= {pend_slot_q, pend_seq_q};
						out_handler_q <= pend_handler_q;
						out_tag_q     <= pend_tag_q;
					end else begin
						out_kind_q <= KIND_IDLE_TICK;
					end
				end
				FUNC_ADD: begin
					out_kind_q <= KIND_ADD;
					if (cmd_q.period == '0) begin
						out_status_q <= ST_BAD_PERIOD;
					end else if (clm_w[NUM_TIMERS]) begin
						out_id_q <= {add_slot_q, cmd_q.new_seq};
					end else begin
						out_status_q <= ST_FULL;
					end
				end
				FUNC_STOP, FUNC_CLEAR: begin
					out_kind_q <= (cmd_q.func == FUNC_STOP) ? KIND_STOP : KIND_CLEAR;
					if (slot_range_bad) begin
						out_status_q <= ST_RANGE;
					end else if (!hit_q) begin
						out_status_q <= ST_STALE;
					end
				end
				default: begin
					out_kind_q <= KIND_IDLE_TICK;
				end
			endcase
		end
	end

	assign busy          = busy_q;
	assign valid         = out_valid_q;
	assign kind          = out_kind_q;
	assign status        = out_status_q;
	assign result_id     = out_id_q;
	assign fired_handler = out_handler_q;
	assign fired_tag     = out_tag_q;
	assign last          = out_last_q;

	// --- assertions ------------------------------------------------------
	`ASSERT_CLK(a_tok_onehot, $onehot0(tok_w), "walk token held by more than one cell")
	`ASSERT_CLK(a_accept_launch, accept |=> (launch_q && busy_q), "accepted beat did not launch a walk")
	`ASSERT_CLK(a_out_in_walk, out_valid_q |-> $past(busy_q), "result beat outside a walk")
	`ASSERT_NEVER(a_fire_idle, evt_any.fire && !busy_q, "fire event with no walk in flight")
	`ASSERT_CLK(a_seq_step, (walk_end && (cmd_q.func == FUNC_ADD) && clm_w[NUM_TIMERS]) |=> (next_seq_q == SEQ_W'($past(next_seq_q) + 1'b1)), "sequence did not advance after add")

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for periodic_timer_bank
// Drives add, stop, clear and tick commands into the timer table and checks
// every result beat (ack, fire or idle tick) against a slot-by-slot prediction of the table.
// ----------------------------------------------------------------------------
module testbench;
	import ptb_pkg::*;

	localparam int CYCLE_LIMIT = 400_000;
	localparam int MAX_REPORTS = 10;

	// one ack or fire as the block should strobe it out
	typedef struct packed {
		kind_t             kind;
		status_t           status;
		logic [ID_W-1:0]   id;
		logic [HND_W-1:0]  handler;
		logic [TAG_W-1:0]  tag;
		logic              last;
	} bank_result_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         func;
	logic [PER_W-1:0]   period;
	logic [HND_W-1:0]   handler_index;
	logic [TAG_W-1:0]   callback_tag;
	logic [ID_W-1:0]    timer_id;
	logic               valid;
	logic [2:0]         kind;
	logic [2:0]         status;
	logic [ID_W-1:0]    result_id;
	logic [HND_W-1:0]   fired_handler;
	logic [TAG_W-1:0]   fired_tag;
	logic               last;

	periodic_timer_bank uut (.*);

	// predicted table contents; only live slots are ever read
	bit [NUM_TIMERS-1:0] in_use = '0;
	logic [PER_W-1:0]    tmr_period  [NUM_TIMERS];
	logic [PER_W-1:0]    tmr_count   [NUM_TIMERS];
	logic [SEQ_W-1:0]    tmr_serial  [NUM_TIMERS];
	logic [HND_W-1:0]    tmr_handler [NUM_TIMERS];
	logic [TAG_W-1:0]    tmr_arg     [NUM_TIMERS];
	logic [SEQ_W-1:0]    serial_next = '0;

	// acks and fires still owed by the block, oldest first
	bank_result_t acks_and_fires[$];

	int fault_count = 0;
	int cycle_count = 0;
	int burst_left  = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case the block hangs or drops beats
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic void note_result(input kind_t k, input status_t st,
		input logic [ID_W-1:0] id, input logic [HND_W-1:0] hnd,
		input logic [TAG_W-1:0] tag, input logic lst);
		acks_and_fires.push_back('{kind: k, status: st, id: id, handler: hnd,
			tag: tag, last: lst});
	endfunction

	// Table update for one accepted command, in the order the block walks it.
	// Fires of a tick leave in ascending slot order; last marks the highest.
	function automatic void predict_bank_response(input func_t f,
		input logic [PER_W-1:0] per, input logic [HND_W-1:0] hnd,
		input logic [TAG_W-1:0] tag, input logic [ID_W-1:0] id);
		int s;
		int free_slot;
		logic [NUM_TIMERS-1:0] firing;
		logic [SLOT_W-1:0] id_slot;
		kind_t ack;
		firing = '0;
		free_slot = -1;
		id_slot = id[ID_W-1:SEQ_W];
		ack = (f == FUNC_STOP) ? KIND_STOP : KIND_CLEAR;
		case (f)
		FUNC_TICK: begin
			for (s = 0; s < NUM_TIMERS; s++) begin
				if (in_use[s]) begin
					tmr_count[s] = tmr_count[s] + 1'b1;
					if (tmr_count[s] >= tmr_period[s]) begin
						tmr_count[s] = '0;
						firing[s] = 1'b1;
					end
				end
			end
			if (firing == '0) begin
				note_result(KIND_IDLE_TICK, ST_OK, '0, '0, '0, 1'b1);
			end else begin
				for (s = 0; s < NUM_TIMERS; s++) begin
					if (firing[s])
						note_result(KIND_FIRE, ST_OK, {SLOT_W'(s), tmr_serial[s]},
							tmr_handler[s], tmr_arg[s], (firing >> (s + 1)) == '0);
				end
			end
		end
		FUNC_ADD: begin
			for (s = NUM_TIMERS - 1; s >= 0; s--) begin
				if (!in_use[s])
					free_slot = s;
			end
			if (per == '0) begin
				note_result(KIND_ADD, ST_BAD_PERIOD, '0, '0, '0, 1'b1);
			end else if (free_slot < 0) begin
				note_result(KIND_ADD, ST_FULL, '0, '0, '0, 1'b1);
			end else begin
				in_use[free_slot]      = 1'b1;
				tmr_period[free_slot]  = per;
				tmr_count[free_slot]   = '0;
				tmr_serial[free_slot]  = serial_next;
				tmr_handler[free_slot] = hnd;
				tmr_arg[free_slot]     = tag;
				serial_next            = serial_next + 1'b1;
				note_result(KIND_ADD, ST_OK, {SLOT_W'(free_slot), tmr_serial[free_slot]},
					'0, '0, 1'b1);
			end
		end
		default: begin
			if (int'(id_slot) >= NUM_TIMERS) begin
				note_result(ack, ST_RANGE, '0, '0, '0, 1'b1);
			end else if (!in_use[id_slot] || tmr_serial[id_slot] != id[SEQ_W-1:0]) begin
				note_result(ack, ST_STALE, '0, '0, '0, 1'b1);
			end else begin
				if (f == FUNC_STOP)
					in_use[id_slot] = 1'b0;
				else
					tmr_count[id_slot] = '0;
				note_result(ack, ST_OK, '0, '0, '0, 1'b1);
			end
		end
		endcase
	endfunction

	function automatic logic [ID_W-1:0] live_id(input int s);
		return {SLOT_W'(s), tmr_serial[s]};
	endfunction

	// random live slot, or -1 with an empty table
	function automatic int pick_live_slot();
		int k;
		int s;
		s = $urandom_range(0, NUM_TIMERS - 1);
		for (k = 0; k < NUM_TIMERS; k++) begin
			if (in_use[(s + k) % NUM_TIMERS])
				return (s + k) % NUM_TIMERS;
		end
		return -1;
	endfunction

	// One command beat. Entered and left at a falling edge. start is left high
	// after the accepting edge; the next call either lowers it or loads the next
	// command in the same step, so a zero gap gives back-to-back beats.
	task automatic issue_command(input func_t f, input logic [PER_W-1:0] per,
		input logic [HND_W-1:0] hnd, input logic [TAG_W-1:0] tag,
		input logic [ID_W-1:0] id);
		int gap;
		if (burst_left > 0) begin
			burst_left--;
			gap = 0;
		end else begin
			gap = $urandom_range(0, 13);
			if ($urandom_range(0, 15) == 0)
				burst_left = $urandom_range(8, 30);
		end
		if (gap != 0) begin
			start <= 1'b0;
			// half the gaps count from the end of the walk, so idle cycles also
			// land after busy drops, not only inside the walk
			if ($urandom_range(0, 1) == 1) begin
				@(posedge clk);
				while (busy)
					@(posedge clk);
				@(negedge clk);
			end
			repeat (gap) @(negedge clk);
		end
		func          <= f;
		period        <= per;
		handler_index <= hnd;
		callback_tag  <= tag;
		timer_id      <= id;
		start         <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_bank_response(f, per, hnd, tag, id);
		@(negedge clk);
	endtask

	task automatic report_fault(input string what, input bank_result_t want,
		input bank_result_t got, input bit have_want);
		fault_count++;
		if (fault_count <= MAX_REPORTS) begin
			if (have_want)
				$display("%0t %s: expected kind %0d status %0d id %05h hnd %02h tag %08h last %0d",
					$time, what, want.kind, want.status, want.id, want.handler, want.tag,
					want.last);
			$display("%0t %s: got      kind %0d status %0d id %05h hnd %02h tag %08h last %0d",
				$time, what, got.kind, got.status, got.id, got.handler, got.tag, got.last);
		end
	endtask

	// every strobed beat is matched against the oldest outstanding prediction
	always @(posedge clk) begin : check_results
		bank_result_t want;
		bank_result_t got;
		if (arst_n && valid === 1'b1) begin
			got = '{kind: kind_t'(kind), status: status_t'(status), id: result_id,
				handler: fired_handler, tag: fired_tag, last: last};
			if (acks_and_fires.size() == 0) begin
				report_fault("unexpected beat", got, got, 1'b0);
			end else begin
				want = acks_and_fires.pop_front();
				if (want !== got)
					report_fault("beat mismatch", want, got, 1'b1);
			end
		end
	end

	// tick on an empty table gives the single idle beat
	task automatic test_idle_tick();
		issue_command(FUNC_TICK, '0, '0, '0, '0);
	endtask

	// zero period rejected; adds with field extremes take slots 0, 1, 2
	task automatic test_add_fields();
		issue_command(FUNC_ADD, '0, '1, '1, '1);
		issue_command(FUNC_ADD, 16'd1, '1, '1, '0);
		issue_command(FUNC_ADD, '1, '0, '0, '1);
		issue_command(FUNC_ADD, 16'd2, 8'h5a, 32'h1234_5678, '0);
	endtask

	// period-1 slot fires every tick; clear holds off the period-2 slot
	task automatic test_fire_and_clear();
		issue_command(FUNC_TICK, '0, '0, '0, '0);
		issue_command(FUNC_CLEAR, '0, '0, '0, live_id(2));
		issue_command(FUNC_TICK, '0, '0, '0, '0);
		issue_command(FUNC_TICK, '0, '0, '0, '0);
	endtask

	// wrong sequence on a live slot, and a free slot with an all-ones id
	task automatic test_stale_ids();
		issue_command(FUNC_CLEAR, '1, '1, '1, live_id(2) ^ 20'h0_8001);
		issue_command(FUNC_STOP, '1, '1, '1, '1);
		issue_command(FUNC_CLEAR, '0, '0, '0, 20'hf_0000);
	endtask

	// stop frees slot 1, a repeated stop is stale, and the next add reuses it
	task automatic test_stop_and_reuse();
		logic [ID_W-1:0] old_id;
		old_id = live_id(1);
		issue_command(FUNC_STOP, '0, '0, '0, old_id);
		issue_command(FUNC_STOP, '0, '0, '0, old_id);
		issue_command(FUNC_ADD, 16'd3, 8'ha5, 32'hdead_beef, '0);
		issue_command(FUNC_TICK, '0, '0, '0, '0);
	endtask

	// empty the table, fill all slots with period 1, overflow it, then one
	// tick fires every slot at once
	task automatic test_table_full();
		int s;
		for (s = 0; s < NUM_TIMERS; s++) begin
			if (in_use[s])
				issue_command(FUNC_STOP, '0, '0, '0, live_id(s));
		end
		for (s = 0; s < NUM_TIMERS; s++)
			issue_command(FUNC_ADD, 16'd1, 8'($urandom), $urandom, 20'($urandom));
		issue_command(FUNC_ADD, 16'd7, 8'($urandom), $urandom, '0);
		issue_command(FUNC_TICK, '0, '0, '0, '0);
		issue_command(FUNC_STOP, '0, '0, '0, live_id(5));
		issue_command(FUNC_ADD, 16'd2, 8'($urandom), $urandom, '0);
	endtask

	// Mostly well-formed traffic: adds with short periods, ticks, and stops and
	// clears aimed at live timers. The rest is stale or random ids, flipped
	// sequence bits, zero and huge periods. Unused fields carry random values.
	task automatic test_random_traffic(input int count);
		int n;
		int pick;
		int s;
		logic [PER_W-1:0] per;
		logic [ID_W-1:0] id;
		for (n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			s = pick_live_slot();
			id = 20'($urandom);
			case ($urandom_range(0, 9))
			0:       per = '0;
			1:       per = 16'($urandom);
			default: per = 16'($urandom_range(1, 5));
			endcase
			if (pick < 33) begin
				issue_command(FUNC_ADD, per, 8'($urandom), $urandom, id);
			end else if (pick < 63) begin
				issue_command(FUNC_TICK, per, 8'($urandom), $urandom, id);
			end else if (pick < 80) begin
				if (s >= 0)
					id = live_id(s);
				issue_command(FUNC_STOP, per, 8'($urandom), $urandom, id);
			end else if (pick < 90) begin
				if (s >= 0)
					id = live_id(s);
				issue_command(FUNC_CLEAR, per, 8'($urandom), $urandom, id);
			end else begin
				if (s >= 0 && $urandom_range(0, 1) == 1)
					id = live_id(s) ^ (20'd1 << $urandom_range(0, SEQ_W - 1));
				issue_command($urandom_range(0, 1) ? FUNC_STOP : FUNC_CLEAR, per,
					8'($urandom), $urandom, id);
			end
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		start         = 1'b0;
		func          = FUNC_TICK;
		period        = '0;
		handler_index = '0;
		callback_tag  = '0;
		timer_id      = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_idle_tick();
		test_add_fields();
		test_fire_and_clear();
		test_stale_ids();
		test_stop_and_reuse();
		test_table_full();
		test_random_traffic(380);

		// drop start, let the last walk finish, then watch for stray beats
		start <= 1'b0;
		while (acks_and_fires.size() != 0)
			@(negedge clk);
		repeat (2 * NUM_TIMERS + 4) @(negedge clk);
		if (fault_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
